// File: rtl/tlpd_pkg.sv
// shared types, widths and constants for the tank level pid pump drive
`timescale 1ns / 1ps
package tlpd_pkg;

   localparam int unsigned CFG_W     = 16;
   localparam int unsigned ECHO_W    = 16;
   localparam int unsigned DT_W      = 16;
   localparam int unsigned DRIVE_W   = 8;
   localparam int unsigned LEVEL_W   = 17;
   localparam int unsigned LVL_WIDE_W = 20;
   localparam int unsigned ERR_W     = 18;
   localparam int unsigned DIFF_W    = 19;
   localparam int unsigned INTEG_W   = 32;
   localparam int unsigned INTEG_SUM_W = 36;
   localparam int unsigned DERIV_W   = 29;
   localparam int unsigned MUL_A_W   = 33;
   localparam int unsigned MUL_B_W   = 16;
   localparam int unsigned PROD_W    = 50;
   localparam int unsigned DIST_W    = 19;
   localparam int unsigned DIST_LSB  = 8;
   localparam int unsigned DRIVE_LSB = 16;
   localparam int unsigned DIV_W     = 34;
   localparam int unsigned DIV_D_W   = 16;
   localparam int unsigned DIV_STEPS = DIV_W / 2;
   localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
   localparam int unsigned CSR_IDX_W = 3;

   // distance factor 0.01715 cm/us in q.16
   localparam logic [MUL_B_W-1:0] DIST_K   = 16'd1124;
   localparam logic [MUL_B_W-1:0] MS_PER_S = 16'd1000;

   localparam logic [CFG_W-1:0] SETPOINT_RST = 16'd3840;
   localparam logic [CFG_W-1:0] HEIGHT_RST   = 16'd6144;
   localparam logic [CFG_W-1:0] KP_RST       = 16'd20480;
   localparam logic [CFG_W-1:0] KI_RST       = 16'd26;
   localparam logic [CFG_W-1:0] KD_RST       = 16'd8960;

   localparam logic signed [LVL_WIDE_W-1:0]  LEVEL_MIN_WIDE = -20'sd65536;
   localparam logic signed [LEVEL_W-1:0]     LEVEL_MIN      = -17'sd65536;
   localparam logic signed [INTEG_SUM_W-1:0] INTEG_MAX_WIDE = 36'sd2147483647;
   localparam logic signed [INTEG_SUM_W-1:0] INTEG_MIN_WIDE = -36'sd2147483648;
   localparam logic signed [INTEG_W-1:0]     INTEG_MAX      = 32'sh7fff_ffff;
   localparam logic signed [INTEG_W-1:0]     INTEG_MIN      = 32'sh8000_0000;
   localparam logic [DRIVE_W-1:0]            DRIVE_MAX      = 8'd255;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SETPOINT = 3'd0,
      CSR_HEIGHT   = 3'd1,
      CSR_KP       = 3'd2,
      CSR_KI       = 3'd3,
      CSR_KD       = 3'd4
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIST,
      ST_LEVEL,
      ST_MUL_EDT,
      ST_DIV_I,
      ST_WAIT_I,
      ST_MUL_DIFF,
      ST_DIV_D,
      ST_WAIT_D,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_SUM,
      ST_DONE
   } seq_state_type;

   typedef struct packed {
      logic               start;
      logic [DIV_W-1:0]   dividend;
      logic [DIV_D_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

endpackage

// File: rtl/tlpd_div.sv
// serial unsigned divider, two quotient bits per cycle
`timescale 1ns / 1ps
module tlpd_div (
   input  logic                  clock,
   input  logic                  reset,
   input  tlpd_pkg::div_req_type div_req,
   output tlpd_pkg::div_rsp_type div_rsp
);
   import tlpd_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_D_W-1:0]   rem_ff, rem_in;
   logic [DIV_W-1:0]     dq_ff, dq_in;
   logic [DIV_D_W-1:0]   divisor_ff, divisor_in;

   logic [DIV_D_W:0]     r1, r2;
   logic                 ge1, ge2;
   logic [DIV_D_W-1:0]   rem1, rem2;
   logic                 last;

   // two restoring steps per cycle
   always_comb begin
      r1   = {rem_ff, dq_ff[DIV_W-1]};
      ge1  = r1 >= {1'b0, divisor_ff};
      rem1 = ge1 ? DIV_D_W'(r1 - {1'b0, divisor_ff}) : r1[DIV_D_W-1:0];
      r2   = {rem1, dq_ff[DIV_W-2]};
      ge2  = r2 >= {1'b0, divisor_ff};
      rem2 = ge2 ? DIV_D_W'(r2 - {1'b0, divisor_ff}) : r2[DIV_D_W-1:0];
   end

   assign last = cnt_ff == DIV_CNT_W'(DIV_STEPS - 1);

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      dq_in      = dq_ff;
      divisor_in = divisor_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         rem_in     = '0;
         dq_in      = div_req.dividend;
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = rem2;
         dq_in  = {dq_ff[DIV_W-3:0], ge1, ge2};
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      dq_ff      <= dq_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = dq_ff;

endmodule

// File: rtl/tank_level_pid_pump_drive_top.sv
// tank level pid pump drive: echo to level, pid law, clamped pump duty
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_ready  | req_echo_width_us, req_elapsed_ms
//   rsp     | out       | rsp_valid / rsp_ready  | rsp_pump_drive, rsp_level
//   csr     | in        | csr_we (no wait)       | csr_index, csr_wdata
//
// between accept and the next ready, one item makes two passes through the
// serial divider, only one when elapsed_ms is 0, and runs its products one at
// a time through the shared 33x17 multiplier
// synchronous active-high reset restores the registers and clears integral and
// previous error; a finished item sits in the output register, so a stalled rsp
// side holds only the final step while the next item is taken once it empties
`timescale 1ns / 1ps
module tank_level_pid_pump_drive_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [tlpd_pkg::ECHO_W-1:0]          req_echo_width_us,
   input  logic [tlpd_pkg::DT_W-1:0]            req_elapsed_ms,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [tlpd_pkg::DRIVE_W-1:0]         rsp_pump_drive,
   output logic signed [tlpd_pkg::LEVEL_W-1:0]  rsp_level,
   input  logic                                 csr_we,
   input  logic [tlpd_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tlpd_pkg::CFG_W-1:0]           csr_wdata
);
   import tlpd_pkg::*;

   // sequencer
   seq_state_type state_ff, state_in;

   // configuration registers
   logic [CFG_W-1:0] setpoint_ff, height_ff, kp_ff, ki_ff, kd_ff;

   // persistent controller state
   logic signed [ERR_W-1:0]   prev_err_ff, prev_err_in;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;

   // working registers for the item in flight
   logic [ECHO_W-1:0]          echo_ff, echo_in;
   logic [DT_W-1:0]            dt_ff, dt_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [PROD_W-1:0]   acc_ff, acc_in;
   logic signed [LEVEL_W-1:0]  level_ff, level_in;
   logic signed [ERR_W-1:0]    err_ff, err_in;
   logic signed [DERIV_W-1:0]  deriv_ff, deriv_in;
   logic                       neg_ff, neg_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [DRIVE_W-1:0]         drive_ff, drive_in;
   logic signed [LEVEL_W-1:0]  rsp_level_ff, rsp_level_in;

   // shared multiplier
   logic signed [MUL_A_W-1:0]  mul_a;
   logic [MUL_B_W-1:0]         mul_b;
   logic signed [PROD_W-1:0]   mul_prod;

   // shared divider
   div_req_type div_req;
   div_rsp_type div_rsp;

   // combinational helpers
   logic [DIST_W-1:0]              echo_dist;
   logic signed [LVL_WIDE_W-1:0]   lvl_wide;
   logic signed [LEVEL_W-1:0]      lvl_sat;
   logic signed [ERR_W-1:0]        err_calc;
   logic signed [DIFF_W-1:0]       diff;
   logic signed [PROD_W-1:0]       prod_mag;
   logic signed [DIV_W:0]          quot_s;
   logic signed [INTEG_SUM_W-1:0]  integ_wide;
   logic signed [INTEG_W-1:0]      integ_sat;
   logic                           acc_pos;
   logic                           acc_big;
   logic                           out_load;

   tlpd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // 33 x 17 signed product, registered into prod_ff
   assign mul_prod = PROD_W'(mul_a) * PROD_W'($signed({1'b0, mul_b}));

   // level = height - echo distance, low side saturated
   assign echo_dist = prod_ff[DIST_LSB +: DIST_W];
   assign lvl_wide  = $signed({(LVL_WIDE_W - CFG_W)'(0), height_ff})
                    - $signed({(LVL_WIDE_W - DIST_W)'(0), echo_dist});
   assign lvl_sat  = (lvl_wide < LEVEL_MIN_WIDE) ? LEVEL_MIN : lvl_wide[LEVEL_W-1:0];
   assign err_calc = $signed({(ERR_W - CFG_W)'(0), setpoint_ff}) - ERR_W'(lvl_sat);

   assign diff = DIFF_W'(err_ff) - DIFF_W'(prev_err_ff);

   // sign and magnitude around the unsigned divider, quotient truncates toward zero
   assign prod_mag = prod_ff[PROD_W-1] ? -prod_ff : prod_ff;
   assign quot_s   = neg_ff ? -$signed({1'b0, div_rsp.quotient})
                            :  $signed({1'b0, div_rsp.quotient});

   // integral update with 32-bit saturation
   assign integ_wide = INTEG_SUM_W'(integ_ff) + INTEG_SUM_W'(quot_s);
   always_comb begin
      if (integ_wide > INTEG_MAX_WIDE) begin
         integ_sat = INTEG_MAX;
      end else if (integ_wide < INTEG_MIN_WIDE) begin
         integ_sat = INTEG_MIN;
      end else begin
         integ_sat = integ_wide[INTEG_W-1:0];
      end
   end

   // drive clamp on the q.16 sum
   assign acc_pos  = !acc_ff[PROD_W-1] && (acc_ff != '0);
   assign acc_big  = |acc_ff[PROD_W-2:DRIVE_LSB+DRIVE_W];
   assign out_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_DIST;
         ST_DIST:     state_in = ST_LEVEL;
         ST_LEVEL:    state_in = ST_MUL_EDT;
         ST_MUL_EDT:  state_in = ST_DIV_I;
         ST_DIV_I:    state_in = ST_WAIT_I;
         ST_WAIT_I:   if (div_rsp.done) state_in = ST_MUL_DIFF;
         ST_MUL_DIFF: state_in = ST_DIV_D;
         ST_DIV_D: begin
            if (dt_ff == '0) state_in = ST_MUL_P;
            else             state_in = ST_WAIT_D;
         end
         ST_WAIT_D:   if (div_rsp.done) state_in = ST_MUL_P;
         ST_MUL_P:    state_in = ST_MUL_I;
         ST_MUL_I:    state_in = ST_MUL_D;
         ST_MUL_D:    state_in = ST_SUM;
         ST_SUM:      state_in = ST_DONE;
         ST_DONE:     if (out_load) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath control per state
   always_comb begin
      req_ready   = 1'b0;
      mul_a       = '0;
      mul_b       = '0;
      div_req     = '0;
      echo_in     = echo_ff;
      dt_in       = dt_ff;
      prod_in     = prod_ff;
      acc_in      = acc_ff;
      level_in    = level_ff;
      err_in      = err_ff;
      deriv_in    = deriv_ff;
      neg_in      = neg_ff;
      integ_in    = integ_ff;
      prev_err_in = prev_err_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               echo_in = req_echo_width_us;
               dt_in   = req_elapsed_ms;
            end
         end
         ST_DIST: begin
            // echo * 0.01715 in q.16
            mul_a   = $signed({(MUL_A_W - ECHO_W)'(0), echo_ff});
            mul_b   = DIST_K;
            prod_in = mul_prod;
         end
         ST_LEVEL: begin
            level_in = lvl_sat;
            err_in   = err_calc;
         end
         ST_MUL_EDT: begin
            mul_a   = MUL_A_W'(err_ff);
            mul_b   = dt_ff;
            prod_in = mul_prod;
         end
         ST_DIV_I: begin
            // error * dt / 1000
            div_req.start    = 1'b1;
            div_req.dividend = prod_mag[DIV_W-1:0];
            div_req.divisor  = MS_PER_S;
            neg_in           = prod_ff[PROD_W-1];
         end
         ST_WAIT_I: begin
            if (div_rsp.done) integ_in = integ_sat;
         end
         ST_MUL_DIFF: begin
            mul_a   = MUL_A_W'(diff);
            mul_b   = MS_PER_S;
            prod_in = mul_prod;
         end
         ST_DIV_D: begin
            // (error - previous error) * 1000 / dt, zero when dt is zero
            prev_err_in = err_ff;
            if (dt_ff == '0) begin
               deriv_in = '0;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = prod_mag[DIV_W-1:0];
               div_req.divisor  = dt_ff;
               neg_in           = prod_ff[PROD_W-1];
            end
         end
         ST_WAIT_D: begin
            if (div_rsp.done) deriv_in = quot_s[DERIV_W-1:0];
         end
         ST_MUL_P: begin
            mul_a   = MUL_A_W'(err_ff);
            mul_b   = kp_ff;
            prod_in = mul_prod;
         end
         ST_MUL_I: begin
            acc_in  = prod_ff;
            mul_a   = MUL_A_W'(integ_ff);
            mul_b   = ki_ff;
            prod_in = mul_prod;
         end
         ST_MUL_D: begin
            acc_in  = acc_ff + prod_ff;
            mul_a   = MUL_A_W'(deriv_ff);
            mul_b   = kd_ff;
            prod_in = mul_prod;
         end
         ST_SUM: begin
            acc_in = acc_ff + prod_ff;
         end
         ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // output register, loaded when it is empty or being drained
   always_comb begin
      drive_in     = drive_ff;
      rsp_level_in = rsp_level_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_level_in = level_ff;
         if (!acc_pos)     drive_in = '0;
         else if (acc_big) drive_in = DRIVE_MAX;
         else              drive_in = acc_ff[DRIVE_LSB +: DRIVE_W];
      end
   end

   // control state, configuration and persistent controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         setpoint_ff  <= SETPOINT_RST;
         height_ff    <= HEIGHT_RST;
         kp_ff        <= KP_RST;
         ki_ff        <= KI_RST;
         kd_ff        <= KD_RST;
         integ_ff     <= '0;
         prev_err_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         integ_ff     <= integ_in;
         prev_err_ff  <= prev_err_in;
         if (csr_we) begin
            unique case (csr_idx_type'(csr_index))
               CSR_SETPOINT: setpoint_ff <= csr_wdata;
               CSR_HEIGHT:   height_ff   <= csr_wdata;
               CSR_KP:       kp_ff       <= csr_wdata;
               CSR_KI:       ki_ff       <= csr_wdata;
               CSR_KD:       kd_ff       <= csr_wdata;
               default: begin
                  // unknown index, write dropped
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      echo_ff      <= echo_in;
      dt_ff        <= dt_in;
      prod_ff      <= prod_in;
      acc_ff       <= acc_in;
      level_ff     <= level_in;
      err_ff       <= err_in;
      deriv_ff     <= deriv_in;
      neg_ff       <= neg_in;
      drive_ff     <= drive_in;
      rsp_level_ff <= rsp_level_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pump_drive = drive_ff;
   assign rsp_level      = rsp_level_ff;

endmodule

// File: rtl/tlpd_checker.sv
// port-level assertions for the tank level pid pump drive, bound to the top level
`timescale 1ns / 1ps
module tlpd_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [tlpd_pkg::DRIVE_W-1:0]         rsp_pump_drive,
   input logic signed [tlpd_pkg::LEVEL_W-1:0]  rsp_level
);
   import tlpd_pkg::*;

   // one item at a time: ready drops right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready still high after an item was accepted");

   // a new result needs the whole sequence, so the result outputs hold still right after an accept
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> ##1 ($stable(rsp_level) && $stable(rsp_pump_drive)))
      else $error("result changed too soon after an accept");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_level)
                                   && $stable(rsp_pump_drive))
      else $error("stalled result dropped or changed");

   // reset empties the output register
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

endmodule

bind tank_level_pid_pump_drive_top tlpd_checker u_tlpd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_pump_drive (rsp_pump_drive),
   .rsp_level      (rsp_level)
);

// File: dv/tb_top.sv
// testbench for the tank level pid pump drive: directed, windup and random items
`timescale 1ns / 1ps
module tb_top;
   import tlpd_pkg::*;

   // run limit, well above the slowest legal run of about 1500 items
   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   // settle time after the last result, a bit over one full item of block latency
   localparam int unsigned SETTLE_CYCLES = 60;
   localparam int unsigned MAX_IDLE = 19;
   localparam int unsigned CSR_IDX_LAST = (1 << CSR_IDX_W) - 1;
   localparam longint LEVEL_TOP = 65535;
   localparam logic [CFG_W-1:0] CFG_ALL_ONES = '1;

   typedef struct {
      logic [DRIVE_W-1:0]        drive;
      logic signed [LEVEL_W-1:0] level;
   } pump_result_type;

   // clock, reset and block ports; the ones the bench drives are known from time zero
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [ECHO_W-1:0] req_echo_width_us = '0;
   logic [DT_W-1:0] req_elapsed_ms = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [DRIVE_W-1:0] rsp_pump_drive;
   logic signed [LEVEL_W-1:0] rsp_level;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_wdata = '0;

   // shadow copy of the registers and the controller state
   logic [CFG_W-1:0] cfg_setpoint = SETPOINT_RST;
   logic [CFG_W-1:0] cfg_height = HEIGHT_RST;
   logic [CFG_W-1:0] cfg_kp = KP_RST;
   logic [CFG_W-1:0] cfg_ki = KI_RST;
   logic [CFG_W-1:0] cfg_kd = KD_RST;
   logic signed [INTEG_W-1:0] pid_integral = '0;
   logic signed [ERR_W-1:0] pid_last_error = '0;

   // predicted results waiting for the block, oldest first
   pump_result_type expected_pump_results[$];

   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   // when clear, the matching side runs without idle cycles
   bit sender_idles = 1'b1;
   bit receiver_idles = 1'b1;

   tank_level_pid_pump_drive_top DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_echo_width_us (req_echo_width_us),
      .req_elapsed_ms    (req_elapsed_ms),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pump_drive    (rsp_pump_drive),
      .rsp_level         (rsp_level),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // one control step: level from echo, pid on the error, clamped duty
   // all arithmetic in 64-bit signed so nothing wraps before the saturations
   function automatic pump_result_type predict_pump_step(input logic [ECHO_W-1:0] echo,
                                                         input logic [DT_W-1:0] dt);
      longint echo_dist;
      longint lvl;
      longint err;
      longint integ;
      longint deriv;
      longint pid_sum;
      longint duty;
      pump_result_type res;
      // echo distance in cm q.8, truncated
      echo_dist = (longint'(echo) * longint'(DIST_K)) >>> DIST_LSB;
      lvl = longint'(cfg_height) - echo_dist;
      if (lvl < longint'(LEVEL_MIN)) lvl = longint'(LEVEL_MIN);
      if (lvl > LEVEL_TOP) lvl = LEVEL_TOP;
      err = longint'(cfg_setpoint) - lvl;
      // integral step truncates toward zero, then saturates to 32 bits signed
      integ = longint'(pid_integral) + (err * longint'(dt)) / longint'(MS_PER_S);
      if (integ > longint'(INTEG_MAX)) integ = longint'(INTEG_MAX);
      if (integ < longint'(INTEG_MIN)) integ = longint'(INTEG_MIN);
      // no derivative when no time has passed
      deriv = 0;
      if (dt != '0)
         deriv = ((err - longint'(pid_last_error)) * longint'(MS_PER_S)) / longint'(dt);
      pid_sum = longint'(cfg_kp) * err + longint'(cfg_ki) * integ + longint'(cfg_kd) * deriv;
      if (pid_sum <= 0) begin
         duty = 0;
      end else begin
         duty = pid_sum >>> DRIVE_LSB;
         if (duty > longint'(DRIVE_MAX)) duty = longint'(DRIVE_MAX);
      end
      pid_integral = integ[INTEG_W-1:0];
      pid_last_error = err[ERR_W-1:0];
      res.drive = duty[DRIVE_W-1:0];
      res.level = lvl[LEVEL_W-1:0];
      return res;
   endfunction

   // register write, mirrored into the shadow copy; unknown indexes change nothing
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_SETPOINT: cfg_setpoint = val;
         CSR_HEIGHT: cfg_height = val;
         CSR_KP: cfg_kp = val;
         CSR_KI: cfg_ki = val;
         CSR_KD: cfg_kd = val;
         default: ;
      endcase
   endtask

   // send one item; valid stays up after the accept unless the next item idles first
   task automatic send_sample(input logic [ECHO_W-1:0] echo, input logic [DT_W-1:0] dt);
      int unsigned gap;
      gap = sender_idles ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_echo_width_us <= echo;
      req_elapsed_ms <= dt;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      expected_pump_results.push_back(predict_pump_step(echo, dt));
   endtask

   // drop valid, wait for every outstanding result, then let the block settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_pump_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic apply_settings(input logic [CFG_W-1:0] setpoint, input logic [CFG_W-1:0] height,
                                 input logic [CFG_W-1:0] kp, input logic [CFG_W-1:0] ki,
                                 input logic [CFG_W-1:0] kd);
      wait_idle();
      write_reg(CSR_SETPOINT, setpoint);
      write_reg(CSR_HEIGHT, height);
      write_reg(CSR_KP, kp);
      write_reg(CSR_KI, ki);
      write_reg(CSR_KD, kd);
   endtask

   // register value biased toward the extremes and toward small gains
   function automatic logic [CFG_W-1:0] pick_setting();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return CFG_ALL_ONES;
         2: return CFG_W'($urandom_range(0, 1023));
         default: return CFG_W'($urandom);
      endcase
   endfunction

   // reset values, zero elapsed time first so the integral stays put
   task automatic test_reset_values();
      send_sample(16'd0, 16'd0);
      send_sample(16'd2000, 16'd100);
      send_sample(16'd2000, 16'd100);
      send_sample(16'd2000, 16'd0);
      send_sample(16'd4000, 16'd1);
   endtask

   // field extremes, including an echo long enough to saturate the level low
   task automatic test_field_extremes();
      send_sample(16'd0, 16'hFFFF);
      send_sample(16'hFFFF, 16'hFFFF);
      send_sample(16'hFFFF, 16'd0);
      send_sample(16'd0, 16'd1);
      send_sample(16'd1, 16'hFFFF);
      send_sample(16'h8000, 16'h8000);
   endtask

   // all registers at zero, all at max, a negative pid sum, and writes to unused indexes
   task automatic test_register_extremes();
      apply_settings('0, '0, '0, '0, '0);
      send_sample(16'd0, 16'd0);
      send_sample(16'hFFFF, 16'hFFFF);
      send_sample(16'd1234, 16'd50);
      apply_settings(CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES, CFG_ALL_ONES);
      send_sample(16'd0, 16'd0);
      send_sample(16'hFFFF, 16'hFFFF);
      send_sample(16'd1234, 16'd50);
      // level far above a zero setpoint, so the sum goes negative
      apply_settings('0, CFG_ALL_ONES, CFG_ALL_ONES, 16'd1, CFG_ALL_ONES);
      send_sample(16'd0, 16'd20);
      send_sample(16'd5, 16'd20);
      // unused indexes must leave every register alone
      wait_idle();
      for (int unsigned idx = int'(CSR_KD) + 1; idx <= CSR_IDX_LAST; idx++)
         write_reg(CSR_IDX_W'(idx), CFG_W'($urandom));
      send_sample(16'd300, 16'd40);
      send_sample(16'd300, 16'd40);
   endtask

   // drive the integral into its negative limit, then all the way to the positive one
   task automatic test_integral_windup();
      apply_settings('0, CFG_ALL_ONES, pick_setting(), pick_setting(), pick_setting());
      for (int i = 0; i < 540; i++) begin
         // a stretch with both sides running flat out
         sender_idles = !(i >= 200 && i < 300);
         receiver_idles = sender_idles;
         send_sample(ECHO_W'($urandom_range(0, 15)), DT_W'($urandom_range(60000, 65535)));
      end
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
      // long echo pins the level at its floor, so the error is at its largest
      apply_settings(CFG_ALL_ONES, pick_setting(), pick_setting(), pick_setting(),
                     pick_setting());
      for (int i = 0; i < 560; i++)
         send_sample(ECHO_W'($urandom_range(60000, 65535)), DT_W'($urandom_range(60000, 65535)));
   endtask

   // random items over several register settings and idle patterns
   task automatic test_random_mix();
      logic [ECHO_W-1:0] echo;
      logic [DT_W-1:0] dt;
      for (int phase = 0; phase < 4; phase++) begin
         apply_settings(pick_setting(), pick_setting(), pick_setting(), pick_setting(),
                        pick_setting());
         sender_idles = (phase != 1);
         receiver_idles = (phase != 2);
         for (int i = 0; i < 80; i++) begin
            // sender holds off until everything in flight has come back
            if (phase == 3 && i == 40) wait_idle();
            case ($urandom_range(0, 3))
               0: echo = ECHO_W'($urandom);
               1: echo = ECHO_W'($urandom_range(0, 4000));
               2: echo = $urandom_range(0, 1) ? '1 : '0;
               default: echo = ECHO_W'($urandom);
            endcase
            case ($urandom_range(0, 4))
               0: dt = '0;
               1: dt = DT_W'($urandom_range(1, 200));
               2: dt = DT_W'($urandom_range(20, 100));
               default: dt = DT_W'($urandom);
            endcase
            send_sample(echo, dt);
         end
      end
      sender_idles = 1'b1;
      receiver_idles = 1'b1;
   endtask

   // result side: stall a random number of cycles before each item while receiver_idles is set
   initial begin : rsp_sink
      int unsigned stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = receiver_idles ? $urandom_range(0, MAX_IDLE) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // compare every accepted result against the oldest prediction
   always @(posedge clock) begin : rsp_check
      pump_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pump_results.size() == 0) begin
            $display("%0t: unexpected item, drive %0d level %0d", $time, rsp_pump_drive,
                     rsp_level);
            error_count++;
         end else begin
            want = expected_pump_results.pop_front();
            if (rsp_pump_drive !== want.drive) begin
               $display("%0t: pump_drive expected %0d actual %0d", $time, want.drive,
                        rsp_pump_drive);
               error_count++;
            end
            if (rsp_level !== want.level) begin
               $display("%0t: level expected %0d actual %0d", $time, want.level, rsp_level);
               error_count++;
            end
         end
      end
   end

   // hang guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_field_extremes();
      test_register_extremes();
      test_integral_windup();
      test_random_mix();
      wait_idle();
      if (error_count == 0 && expected_pump_results.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
